// ----- hdl/division_hash_bucket_table_unit_defines.svh -----
// Assertion macros shared by the division hash bucket table RTL.
`ifndef DIVISION_HASH_BUCKET_TABLE_UNIT_DEFINES_SVH
`define DIVISION_HASH_BUCKET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define DHBT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dhbt: invariant violated");
`define DHBT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhbt: implication violated");
`else
`define DHBT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DHBT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/dhbt_pkg.sv -----
// Package with the field widths, command and status codes and the modulo-three hash.
`default_nettype none

package dhbt_pkg;

    localparam int CMD_W       = 2;
    localparam int KEY_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int BUCKET_W    = 2;
    localparam int PROBE_W     = 5;
    localparam int NUM_BUCKETS = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HASH   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_CLEARED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] STS_HASHED   = 3'd5;

    // Four is one modulo three, so the base-four digits can simply be summed.
    function automatic logic [BUCKET_W-1:0] mod3(input logic [KEY_W-1:0] k);
        logic [3:0] s;
        s = {2'b00, k[1:0]} + {2'b00, k[3:2]} + {2'b00, k[5:4]} + {2'b00, k[7:6]};
        case (s)
            4'd1, 4'd4, 4'd7, 4'd10: mod3 = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11: mod3 = 2'd2;
            default:                 mod3 = 2'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dhbt_ifs.sv -----
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface dhbt_req_if
    import dhbt_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface dhbt_rsp_if
    import dhbt_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [PROBE_W-1:0]  probes;

    modport source (output valid, output status, output bucket, output probes, input ready);
    modport sink   (input valid, input status, input bucket, input probes, output ready);
endinterface

`default_nettype wire

// ----- hdl/division_hash_bucket_table_unit.sv -----
// Top level of the division hash bucket table: control sequencer and slot memory.
//
// The block takes command items on req (cmd, key) and returns one result item on
// rsp (status, bucket, probes) for each, in order. Keys are hashed to bucket
// key mod 3; each bucket holds DEPTH keys in a single-port-write, registered-read
// slot memory, with the three fill counts kept in flip-flops.
// Clear, insert and hash commands pass from acceptance through the result registers
// into the output register. A search first scans the slot memory of its bucket,
// one slot per cycle up to the bucket's fill count at acceptance, and the scan
// stops at the first hit.
// One item is worked on at a time; req.ready is high whenever no item is in work.
// A result waits in the output register while the receiver stalls, and the next
// item is accepted meanwhile; that item's result is then held back until the
// output register frees up, and no further item is accepted until it has moved.
// Reset empties all buckets and the output register; no memory clearing is needed,
// since a slot is only read after it has been written.
`default_nettype none

`include "division_hash_bucket_table_unit_defines.svh"

module division_hash_bucket_table_unit
    import dhbt_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    dhbt_req_if.sink    req,
    dhbt_rsp_if.source  rsp
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int MEM_N = NUM_BUCKETS * DEPTH;
    localparam int AW    = $clog2(MEM_N);
    localparam int PW    = (CW > PROBE_W) ? CW : PROBE_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [BUCKET_W-1:0] bkt_reg, bkt_next;
    logic [CW-1:0]       scan_fill_reg, scan_fill_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BUCKET_W-1:0] res_bucket_reg, res_bucket_next;
    logic [PROBE_W-1:0]  res_probes_reg, res_probes_next;
    logic [CW-1:0]       fill_cnt_reg [NUM_BUCKETS];
    logic [CW-1:0]       fill_cnt_next [NUM_BUCKETS];

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic [PROBE_W-1:0]  out_probes_reg;
    logic                out_load;

    logic [KEY_W-1:0]    mem [MEM_N];
    logic [KEY_W-1:0]    rdata_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       waddr, raddr;

    logic [BUCKET_W-1:0] hb;
    logic [CW-1:0]       cur_fill;
    logic                full;
    logic                hit;

    function automatic logic [AW-1:0] slot_addr(input logic [BUCKET_W-1:0] b,
                                                 input logic [IW-1:0] idx);
        slot_addr = AW'(b) * AW'(DEPTH) + AW'(idx);
    endfunction

    function automatic logic [PROBE_W-1:0] to_probes(input logic [CW-1:0] v);
        logic [PW-1:0] w;
        w = PW'(v);
        to_probes = w[PROBE_W-1:0];
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign hb        = mod3(req.key);
    assign full      = (cur_fill == CW'(DEPTH));
    assign hit       = cmp_valid_reg && (rdata_reg == key_reg);
    assign waddr     = slot_addr(hb, cur_fill[IW-1:0]);
    assign raddr     = slot_addr(bkt_reg, issue_reg[IW-1:0]);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        cur_fill = fill_cnt_reg[0];
        for (int b = 1; b < NUM_BUCKETS; b++)
        begin
            if (hb == BUCKET_W'(b))
            begin
                cur_fill = fill_cnt_reg[b];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        bkt_next        = bkt_reg;
        scan_fill_next  = scan_fill_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_bucket_next = res_bucket_reg;
        res_probes_next = res_probes_reg;
        fill_cnt_next   = fill_cnt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = req.key;
                    bkt_next        = hb;
                    res_bucket_next = hb;
                    res_probes_next = '0;
                    state_next      = ST_EMIT;
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            for (int b = 0; b < NUM_BUCKETS; b++)
                            begin
                                fill_cnt_next[b] = '0;
                            end
                            res_status_next = STS_CLEARED;
                            res_bucket_next = '0;
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = STS_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                res_status_next = STS_INSERTED;
                                res_probes_next = to_probes(cur_fill);
                                for (int b = 0; b < NUM_BUCKETS; b++)
                                begin
                                    if (hb == BUCKET_W'(b))
                                    begin
                                        fill_cnt_next[b] = cur_fill + CW'(1);
                                    end
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            scan_fill_next = cur_fill;
                            issue_next     = '0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            res_status_next = STS_HASHED;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_status_next = STS_FOUND;
                    res_probes_next = to_probes(CW'(cmp_idx_reg) + CW'(1));
                    state_next      = ST_EMIT;
                end
                else if (issue_reg < scan_fill_reg)
                begin
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IW-1:0];
                    issue_next     = issue_reg + CW'(1);
                end
                else
                begin
                    res_status_next = STS_MISSING;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                fill_cnt_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            fill_cnt_reg  <= fill_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        bkt_reg        <= bkt_next;
        scan_fill_reg  <= scan_fill_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_bucket_reg <= res_bucket_next;
        res_probes_reg <= res_probes_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bucket_reg <= res_bucket_reg;
            out_probes_reg <= res_probes_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= req.key;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.bucket = out_bucket_reg;
    assign rsp.probes = out_probes_reg;

    `DHBT_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, (fill_cnt_reg[0] <= CW'(DEPTH)) && (fill_cnt_reg[1] <= CW'(DEPTH)) && (fill_cnt_reg[2] <= CW'(DEPTH)))
    `DHBT_ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, issue_reg <= scan_fill_reg)
    `DHBT_ASSERT_IMPLIES(a_cmp_after_read, clk, rst_n, cmp_valid_reg, $past(mem_re))

endmodule

`default_nettype wire
